// ----- rtl/sgls_pkg.sv -----
// Shared types, constants and splat pattern functions for the sensor grid LED splat block.
package sgls_pkg;

    // Field types of the request and response channels
    typedef logic [1:0] cmd_t;
    typedef logic [3:0] srow_t;
    typedef logic [2:0] scol_t;
    typedef logic [3:0] lrow_t;
    typedef logic [4:0] lcol_t;
    typedef logic [7:0] byte_t;

    // Command codes
    localparam cmd_t CMD_CLEAR = 2'd0;
    localparam cmd_t CMD_ADD   = 2'd1;
    localparam cmd_t CMD_READ  = 2'd2;
    localparam cmd_t CMD_WRITE = 2'd3;

    // Frame geometry and defaults
    localparam int    SENSOR_ROW_COUNT_DEF = 12;
    localparam int    LED_COL_COUNT        = 26;
    localparam int    ROW_BITS             = LED_COL_COUNT * 8;
    localparam byte_t FULL_SCALE_RESET     = 8'd255;

    // Register index of full_scale
    localparam logic REG_FULL_SCALE = 1'b0;

    // Left LED column of each sensor column
    function automatic lcol_t col_base(input scol_t scol);
        lcol_t b;
        case (scol)
            3'd0:    b = 5'd0;
            3'd1:    b = 5'd3;
            3'd2:    b = 5'd6;
            3'd3:    b = 5'd10;
            3'd4:    b = 5'd13;
            3'd5:    b = 5'd16;
            3'd6:    b = 5'd20;
            default: b = 5'd23;
        endcase
        return b;
    endfunction

    // Amount a sensor at column scol adds to LED column col of a row it touches
    function automatic byte_t splat_amount(input scol_t scol, input lcol_t col,
                                           input byte_t half, input byte_t quarter);
        logic signed [6:0] d;
        byte_t amt;
        d   = $signed({2'b00, col}) - $signed({2'b00, col_base(scol)});
        amt = '0;
        case (scol) inside
            3'd0:
            begin
                if (d == 7'sd0 || d == 7'sd1)
                    amt = half;
                else if (d == 7'sd2 || d == 7'sd3)
                    amt = quarter;
            end
            3'd7:
            begin
                if (d == -7'sd1 || d == 7'sd0)
                    amt = quarter;
                else if (d == 7'sd1 || d == 7'sd2)
                    amt = half;
            end
            3'd2, 3'd5:
            begin
                if (d == -7'sd1 || d == 7'sd0 || d == 7'sd3 || d == 7'sd4)
                    amt = quarter;
                else if (d == 7'sd1 || d == 7'sd2)
                    amt = half;
            end
            default:
            begin
                if (d == -7'sd1 || d == 7'sd0 || d == 7'sd2 || d == 7'sd3)
                    amt = quarter;
                else if (d == 7'sd1)
                    amt = half;
            end
        endcase
        return amt;
    endfunction

endpackage

// ----- rtl/sgls_req_if.sv -----
// Request channel: command and its operands with a valid/ready handshake.
interface sgls_req_if;
    import sgls_pkg::*;

    logic  valid;
    logic  ready;
    cmd_t  cmd;
    srow_t sensor_row;
    scol_t sensor_col;
    byte_t reading;
    byte_t cal_max;
    byte_t cal_min;
    lrow_t led_row;
    lcol_t led_col;
    byte_t write_value;

    modport source (output valid, cmd, sensor_row, sensor_col, reading, cal_max, cal_min,
                    led_row, led_col, write_value, input ready);
    modport sink (input valid, cmd, sensor_row, sensor_col, reading, cal_max, cal_min,
                  led_row, led_col, write_value, output ready);
endinterface

// ----- rtl/sgls_rsp_if.sv -----
// Response channel: LED brightness returned by a read request.
interface sgls_rsp_if;
    import sgls_pkg::*;

    logic  valid;
    logic  ready;
    byte_t read_value;

    modport source (output valid, read_value, input ready);
    modport sink (input valid, read_value, output ready);
endinterface

// ----- rtl/sgls_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module sgls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register read data; data holds between reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end
endmodule

// ----- rtl/sensor_grid_to_led_splat.sv -----
// Top level of the sensor grid LED splat block: frame store, sequencer and register port.
//
// The LED frame (SENSOR_ROW_COUNT-1 rows of 26 bytes) lives in one RAM with one row of
// 26 bytes per word, so an add or write request reads a row and writes it back, and a
// read request only reads a row. A request is taken when the sequencer is idle.
// Clear writes zero to every LED row, one row a cycle. Read and write LED go through
// accept, row read, then deliver or write back; the read result sits in an output
// register so the next request is taken while it waits. Add sensor goes through accept,
// clamp and multiply, the bit-serial divider, then a row read and write back for each
// of the one or two touched LED rows; equal or inverted calibration skips the divider.
// A sensor row beyond the grid is dropped in the accept cycle. After reset a clearing
// pass writes zero to every row, one row a cycle, before the first request is taken;
// register writes are taken at any time.
module sensor_grid_to_led_splat #(
    parameter int SENSOR_ROW_COUNT = sgls_pkg::SENSOR_ROW_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sgls_req_if.sink   req,
    sgls_rsp_if.source rsp,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    import sgls_pkg::*;

    localparam int FRAME_ROWS = SENSOR_ROW_COUNT - 1;
    localparam int ROW_W      = (FRAME_ROWS > 1) ? $clog2(FRAME_ROWS) : 1;

    localparam logic [5:0]       SROW_LIMIT = 6'(SENSOR_ROW_COUNT);
    localparam logic [5:0]       SROW_LAST  = 6'(SENSOR_ROW_COUNT - 1);
    localparam logic [5:0]       LROW_LIMIT = 6'(FRAME_ROWS);
    localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(FRAME_ROWS - 1);
    localparam lcol_t            LCOL_LIMIT = 5'(LED_COL_COUNT);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MAP   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_MOD   = 3'd5;
    localparam logic [2:0] ST_RDOUT = 3'd6;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [ROW_W-1:0] clr_row_reg, clr_row_next;
    logic [3:0]       div_cnt_reg, div_cnt_next;
    logic             out_valid_reg, out_valid_next;
    byte_t            full_scale_reg, full_scale_next;

    // Request operands and datapath
    cmd_t             op_reg, op_next;
    scol_t            scol_reg, scol_next;
    byte_t            reading_reg, reading_next;
    byte_t            cmax_reg, cmax_next;
    byte_t            cmin_reg, cmin_next;
    lcol_t            lcol_reg, lcol_next;
    byte_t            wval_reg, wval_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] row2_reg, row2_next;
    logic             second_reg, second_next;
    logic             rd_zero_reg, rd_zero_next;
    logic [7:0]       rem_reg, rem_next;
    logic [15:0]      quo_reg, quo_next;
    logic [7:0]       den_reg, den_next;
    byte_t            br_reg, br_next;
    byte_t            out_data_reg, out_data_next;

    // Frame RAM ports
    logic                ram_wr_en, ram_rd_en;
    logic [ROW_W-1:0]    ram_wr_addr;
    logic [ROW_BITS-1:0] ram_wr_data, ram_rd_data;

    // Combinational helpers
    logic [5:0]          srow6, lrow6, srow_m1;
    logic                in_range;
    byte_t               v_hi, v_clamp, v_diff;
    logic [8:0]          rem_sh;
    logic                div_ge;
    logic [8:0]          rem_sub;
    logic [ROW_BITS-1:0] row_mod;
    byte_t               half, quarter;
    logic                cfg_wr;

    sgls_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (FRAME_ROWS),
        .ADDR_W(ROW_W)
    ) u_frame (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(row_reg),
        .rd_data(ram_rd_data)
    );

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_FULL_SCALE) ? {24'd0, full_scale_reg} : 32'd0;

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_data_reg;

    // Address checks on the incoming request
    assign srow6    = {2'b00, req.sensor_row};
    assign lrow6    = {2'b00, req.led_row};
    assign srow_m1  = srow6 - 6'd1;
    assign in_range = (lrow6 < LROW_LIMIT) && (req.led_col < LCOL_LIMIT);

    // Clamp the reading to max, then to min
    assign v_hi    = (reading_reg > cmax_reg) ? cmax_reg : reading_reg;
    assign v_clamp = (v_hi < cmin_reg) ? cmin_reg : v_hi;
    assign v_diff  = cmax_reg - v_clamp;

    // One restoring divider step
    assign rem_sh  = {rem_reg, quo_reg[15]};
    assign div_ge  = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    assign half    = {1'b0, br_reg[7:1]};
    assign quarter = {2'b00, br_reg[7:2]};

    // Modified row: splat add or single byte write
    always_comb
    begin
        for (int c = 0; c < LED_COL_COUNT; c++)
        begin
            if (op_reg == CMD_WRITE)
                row_mod[c*8 +: 8] = (lcol_reg == 5'(c)) ? wval_reg : ram_rd_data[c*8 +: 8];
            else
                row_mod[c*8 +: 8] = ram_rd_data[c*8 +: 8]
                                    + splat_amount(scol_reg, 5'(c), half, quarter);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_row_next    = clr_row_reg;
        div_cnt_next    = div_cnt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        full_scale_next = full_scale_reg;
        op_next         = op_reg;
        scol_next       = scol_reg;
        reading_next    = reading_reg;
        cmax_next       = cmax_reg;
        cmin_next       = cmin_reg;
        lcol_next       = lcol_reg;
        wval_next       = wval_reg;
        row_next        = row_reg;
        row2_next       = row2_reg;
        second_next     = second_reg;
        rd_zero_next    = rd_zero_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        den_next        = den_reg;
        br_next         = br_reg;
        out_data_next   = out_data_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        ram_wr_addr     = row_reg;
        ram_wr_data     = row_mod;

        if (cfg_wr && paddr[2] == REG_FULL_SCALE)
            full_scale_next = pwdata[7:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_row_reg;
                ram_wr_data = '0;
                if (clr_row_reg == ROW_LAST)
                    state_next = ST_IDLE;
                else
                    clr_row_next = clr_row_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.cmd;
                    scol_next    = req.sensor_col;
                    reading_next = req.reading;
                    cmax_next    = req.cal_max;
                    cmin_next    = req.cal_min;
                    lcol_next    = req.led_col;
                    wval_next    = req.write_value;
                    rd_zero_next = 1'b0;
                    unique case (req.cmd)
                        CMD_CLEAR:
                        begin
                            clr_row_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        CMD_ADD:
                        begin
                            if (srow6 < SROW_LIMIT)
                            begin
                                row_next    = (srow6 == 6'd0) ? '0 : srow_m1[ROW_W-1:0];
                                row2_next   = srow6[ROW_W-1:0];
                                second_next = (srow6 != 6'd0) && (srow6 != SROW_LAST);
                                state_next  = ST_MAP;
                            end
                        end
                        CMD_READ:
                        begin
                            if (in_range)
                            begin
                                row_next   = lrow6[ROW_W-1:0];
                                state_next = ST_RD;
                            end
                            else
                            begin
                                rd_zero_next = 1'b1;
                                state_next   = ST_RDOUT;
                            end
                        end
                        CMD_WRITE:
                        begin
                            if (in_range)
                            begin
                                row_next   = lrow6[ROW_W-1:0];
                                state_next = ST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MAP:
            begin
                // Equal calibration maps to zero, inverted to full scale
                if (cmin_reg == cmax_reg)
                begin
                    br_next    = '0;
                    state_next = ST_RD;
                end
                else if (cmin_reg > cmax_reg)
                begin
                    br_next    = full_scale_reg;
                    state_next = ST_RD;
                end
                else
                begin
                    quo_next     = 16'(v_diff) * 16'(full_scale_reg);
                    rem_next     = '0;
                    den_next     = cmax_reg - cmin_reg;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next     = div_ge ? rem_sub[7:0] : rem_sh[7:0];
                quo_next     = {quo_reg[14:0], div_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 4'hF)
                begin
                    br_next    = {quo_reg[6:0], div_ge};
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                // Rows are read and written strictly in turn, so no forwarding is needed
                ram_rd_en  = 1'b1;
                state_next = (op_reg == CMD_READ) ? ST_RDOUT : ST_MOD;
            end
            ST_MOD:
            begin
                ram_wr_en = 1'b1;
                if (op_reg == CMD_ADD && second_reg)
                begin
                    row_next    = row2_reg;
                    second_next = 1'b0;
                    state_next  = ST_RD;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_RDOUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_zero_reg ? '0 : ram_rd_data[{lcol_reg, 3'b000} +: 8];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_row_reg    <= '0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            full_scale_reg <= FULL_SCALE_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            clr_row_reg    <= clr_row_next;
            div_cnt_reg    <= div_cnt_next;
            out_valid_reg  <= out_valid_next;
            full_scale_reg <= full_scale_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        scol_reg     <= scol_next;
        reading_reg  <= reading_next;
        cmax_reg     <= cmax_next;
        cmin_reg     <= cmin_next;
        lcol_reg     <= lcol_next;
        wval_reg     <= wval_next;
        row_reg      <= row_next;
        row2_reg     <= row2_next;
        second_reg   <= second_next;
        rd_zero_reg  <= rd_zero_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        den_reg      <= den_next;
        br_reg       <= br_next;
        out_data_reg <= out_data_next;
    end

    // No request is taken while a frame row is being written
    a_no_wr_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !ram_wr_en)
        else $error("frame write while idle");

    // Row read and row write never share a cycle
    a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_rd_en && ram_wr_en))
        else $error("frame read and write in the same cycle");

    // A write back always follows the row read of the same row
    a_mod_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |-> ($past(state_reg) == ST_RD && $stable(row_reg)))
        else $error("write back without a preceding row read");

    // A response appears only out of the deliver state
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> ($past(state_reg) == ST_RDOUT))
        else $error("response raised outside the deliver state");
endmodule
